@@ rtl/atlm_pkg.sv @@
// shared types, result kind codes and register indexes for the allowed-token logit mask
// no dependencies
package atlm_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_IDX_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] KIND_KEPT      = 3'd0;
    localparam logic [2:0] KIND_MASKED    = 3'd1;
    localparam logic [2:0] KIND_ACCEPTED  = 3'd2;
    localparam logic [2:0] KIND_INVALID   = 3'd3;
    localparam logic [2:0] KIND_DUPLICATE = 3'd4;
    localparam logic [2:0] KIND_OVER      = 3'd5;
    localparam logic [2:0] KIND_MISPLACED = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_VOCAB_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS = 2'd2;

    localparam logic [16:0] RST_VOCAB_SIZE = 17'd65536;
    localparam logic [31:0] RST_MASK_BITS  = 32'hFF80_0000;
    localparam logic [10:0] RST_MAX_TOKENS = 11'd1024;

    typedef struct packed {
        logic [2:0]           kind;
        logic [31:0]          logit;
        logic [15:0]          position;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic                 row_end;
        logic                 empty_row;
    } t_item;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

@@ rtl/atlm_in_if.sv @@
// input channel: token entries and logits, valid/ready handshake
// no dependencies
interface atlm_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] tok_id;
    logic [31:0] logit_bits;

    modport source(output valid, output mode, output tok_id, output logit_bits, input ready);
    modport sink(input valid, input mode, input tok_id, input logit_bits, output ready);
endinterface

@@ rtl/atlm_out_if.sv @@
// result channel: kind, masked logit and running counts, valid/ready handshake
// no dependencies
interface atlm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [15:0] position;
    logic        row_end;
    logic [31:0] unique_total;
    logic [31:0] invalid_total;
    logic [31:0] duplicate_total;
    logic [31:0] empty_rows;
    logic        error_seen;

    modport source(output valid, output kind, output value, output position, output row_end,
                   output unique_total, output invalid_total, output duplicate_total,
                   output empty_rows, output error_seen, input ready);
    modport sink(input valid, input kind, input value, input position, input row_end,
                 input unique_total, input invalid_total, input duplicate_total,
                 input empty_rows, input error_seen, output ready);
endinterface

@@ rtl/allowed_token_logit_mask.sv @@
// allowed-token logit mask: one item per cycle unless the output stalls, result registered
// in the lookup and output stages; throughput set by the bitmap read-modify-write on one read
// and one write port, forwarded; synchronous active-low reset; then a clearing pass zeroes
// the bitmap one word a cycle with input ready low; configuration writes are taken throughout
// depends on atlm_pkg, atlm_in_if, atlm_out_if, atlm_classify, atlm_bitmap, atlm_resolve
module allowed_token_logit_mask #(
    parameter int VOCAB_MAX  = 65536,
    parameter int MAX_TOKENS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [atlm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    atlm_in_if.sink                        i_in,
    atlm_out_if.source                     o_out
);
    import atlm_pkg::*;

    localparam int DEPTH   = (VOCAB_MAX + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W   = $clog2(VOCAB_MAX);
    localparam int VOCAB_W = $clog2(VOCAB_MAX + 1);
    localparam int ENT_W   = $clog2(MAX_TOKENS + 1);

    logic [16:0] r_vocab_size;
    logic [31:0] r_mask_bits;
    logic [10:0] r_max_tokens;

    logic [VOCAB_W-1:0]   vocab_eff;
    logic [ENT_W-1:0]     limit_eff;
    logic                 accept;
    logic                 busy;
    logic                 stage_ready;
    t_item                item;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] word;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vocab_size <= RST_VOCAB_SIZE;
            r_mask_bits  <= RST_MASK_BITS;
            r_max_tokens <= RST_MAX_TOKENS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOCAB_SIZE: r_vocab_size <= i_cfg_data[16:0];
                CFG_MASK_BITS:  r_mask_bits  <= i_cfg_data;
                CFG_MAX_TOKENS: r_max_tokens <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // clamp register values into the supported ranges
    always_comb begin
        if (r_vocab_size == '0) begin
            vocab_eff = VOCAB_W'(1);
        end else if (32'(r_vocab_size) > 32'(VOCAB_MAX)) begin
            vocab_eff = VOCAB_W'(VOCAB_MAX);
        end else begin
            vocab_eff = VOCAB_W'(r_vocab_size);
        end
        if (r_max_tokens == '0) begin
            limit_eff = ENT_W'(1);
        end else if (32'(r_max_tokens) > 32'(MAX_TOKENS)) begin
            limit_eff = ENT_W'(MAX_TOKENS);
        end else begin
            limit_eff = ENT_W'(r_max_tokens);
        end
    end

    assign i_in.ready = !busy && stage_ready;
    assign accept     = i_in.valid && i_in.ready;

    atlm_classify #(
        .POS_W   (POS_W),
        .VOCAB_W (VOCAB_W),
        .ENT_W   (ENT_W),
        .ADDR_W  (ADDR_W)
    ) u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_mode       (i_in.mode),
        .i_tok_id     (i_in.tok_id),
        .i_logit_bits (i_in.logit_bits),
        .i_vocab_eff  (vocab_eff),
        .i_limit_eff  (limit_eff),
        .o_item       (item),
        .o_rd_addr    (rd_addr)
    );

    atlm_bitmap #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_data (wr_data),
        .o_rd_data (word),
        .o_busy    (busy)
    );

    atlm_resolve u_resolve (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (item),
        .i_mask_bits   (r_mask_bits),
        .i_word        (word),
        .o_wr_en       (wr_en),
        .o_wr_data     (wr_data),
        .o_stage_ready (stage_ready),
        .o_out         (o_out)
    );

endmodule

@@ rtl/atlm_bitmap.sv @@
// allowed-token bitmap: word memory with registered read, write forwarding, clearing pass
// depends on atlm_pkg
module atlm_bitmap #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [ADDR_W-1:0]              i_rd_addr,
    input  logic                           i_wr_en,
    input  logic [atlm_pkg::WORD_BITS-1:0] i_wr_data,
    output logic [atlm_pkg::WORD_BITS-1:0] o_rd_data,
    output logic                           o_busy
);
    import atlm_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd;
    logic [ADDR_W-1:0]    r_rd_addr;
    logic [WORD_BITS-1:0] r_fw_data;
    logic [ADDR_W-1:0]    r_fw_addr;
    logic                 r_fw_vld;
    logic                 r_busy;
    logic [ADDR_W-1:0]    r_clr_addr;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // clearing pass owns the write port after reset; item writes go to the held read address
    always_comb begin
        if (r_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = r_rd_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd      <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (wr_en) begin
            r_fw_data <= wr_data;
            r_fw_addr <= wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_fw_vld   <= 1'b0;
        end else if (r_busy) begin
            r_fw_vld <= 1'b0;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end else if (i_wr_en) begin
            r_fw_vld <= 1'b1;
        end
    end

    // most recent write wins over a read taken at the same edge
    assign o_rd_data = (r_fw_vld && (r_fw_addr == r_rd_addr)) ? r_fw_data : r_rd;
    assign o_busy    = r_busy;

endmodule

@@ rtl/atlm_classify.sv @@
// front stage: row position and entry count, class of each item, bitmap read address
// depends on atlm_pkg
module atlm_classify #(
    parameter int POS_W   = 16,
    parameter int VOCAB_W = 17,
    parameter int ENT_W   = 11,
    parameter int ADDR_W  = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_mode,
    input  logic [31:0]          i_tok_id,
    input  logic [31:0]          i_logit_bits,
    input  logic [VOCAB_W-1:0]   i_vocab_eff,
    input  logic [ENT_W-1:0]     i_limit_eff,
    output atlm_pkg::t_item      o_item,
    output logic [ADDR_W-1:0]    o_rd_addr
);
    import atlm_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [ENT_W-1:0] r_entries;
    logic [ENT_W-1:0] n_entries;

    logic [31:0] idx;
    logic        last;
    logic        lookup;

    assign last = (32'(r_pos) + 32'd1) >= 32'(i_vocab_eff);
    assign idx  = i_mode ? 32'(r_pos) : i_tok_id;

    always_comb begin
        o_item           = '0;
        o_item.logit     = i_logit_bits;
        o_item.bit_idx   = idx[BIT_IDX_W-1:0];
        n_pos            = r_pos;
        n_entries        = r_entries;
        lookup           = 1'b0;
        if (i_mode) begin
            lookup          = 1'b1;
            o_item.kind     = KIND_KEPT;
            o_item.position = 16'(r_pos);
            o_item.row_end  = last;
            if (last) begin
                o_item.empty_row = (r_entries == '0);
                n_pos            = '0;
                n_entries        = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end else if (r_pos != '0) begin
            o_item.kind = KIND_MISPLACED;
        end else if (r_entries >= i_limit_eff) begin
            o_item.kind = KIND_OVER;
        end else begin
            n_entries = r_entries + 1'b1;
            if (i_tok_id >= 32'(i_vocab_eff)) begin
                o_item.kind = KIND_INVALID;
            end else begin
                lookup      = 1'b1;
                o_item.kind = KIND_ACCEPTED;
            end
        end
        o_rd_addr = lookup ? ADDR_W'(idx >> BIT_IDX_W) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_entries <= '0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_entries <= n_entries;
        end
    end

endmodule

@@ rtl/atlm_resolve.sv @@
// back stage: bitmap lookup result, write-back word, saturating counts, output register
// depends on atlm_pkg and atlm_out_if
module atlm_resolve (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  atlm_pkg::t_item                i_item,
    input  logic [31:0]                    i_mask_bits,
    input  logic [atlm_pkg::WORD_BITS-1:0] i_word,
    output logic                           o_wr_en,
    output logic [atlm_pkg::WORD_BITS-1:0] o_wr_data,
    output logic                           o_stage_ready,
    atlm_out_if.source                     o_out
);
    import atlm_pkg::*;

    t_item       r_b;
    logic        r_b_vld;
    logic        r_o_vld;
    logic [2:0]  r_kind;
    logic [31:0] r_value;
    logic [15:0] r_position;
    logic        r_row_end;
    logic [31:0] r_unique;
    logic [31:0] r_invalid;
    logic [31:0] r_duplicate;
    logic [31:0] r_empty;
    logic        r_error;

    logic [2:0]           n_kind;
    logic [31:0]          n_value;
    logic [31:0]          n_unique;
    logic [31:0]          n_invalid;
    logic [31:0]          n_duplicate;
    logic [31:0]          n_empty;
    logic                 n_error;
    logic                 b_adv;
    logic                 hit;
    logic [WORD_BITS-1:0] onehot;

    assign b_adv         = r_b_vld && (!r_o_vld || o_out.ready);
    assign o_stage_ready = !r_b_vld || b_adv;
    assign hit           = i_word[r_b.bit_idx];
    assign onehot        = WORD_BITS'(1) << r_b.bit_idx;

    always_comb begin
        n_kind    = r_b.kind;
        n_value   = '0;
        o_wr_data = i_word;
        o_wr_en   = 1'b0;
        unique case (r_b.kind)
            KIND_KEPT: begin
                // reading a bit clears it
                n_kind    = hit ? KIND_KEPT : KIND_MASKED;
                n_value   = hit ? r_b.logit : i_mask_bits;
                o_wr_data = i_word & ~onehot;
                o_wr_en   = b_adv;
            end
            KIND_ACCEPTED: begin
                n_kind    = hit ? KIND_DUPLICATE : KIND_ACCEPTED;
                o_wr_data = i_word | onehot;
                o_wr_en   = b_adv && !hit;
            end
            default: begin
                n_kind = r_b.kind;
            end
        endcase

        n_unique    = (n_kind == KIND_ACCEPTED)  ? sat_inc(r_unique)    : r_unique;
        n_invalid   = (n_kind == KIND_INVALID)   ? sat_inc(r_invalid)   : r_invalid;
        n_duplicate = (n_kind == KIND_DUPLICATE) ? sat_inc(r_duplicate) : r_duplicate;
        n_empty     = r_b.empty_row ? sat_inc(r_empty) : r_empty;
        n_error     = r_error || r_b.empty_row || (n_kind == KIND_INVALID)
                      || (n_kind == KIND_DUPLICATE) || (n_kind == KIND_OVER)
                      || (n_kind == KIND_MISPLACED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld     <= 1'b0;
            r_o_vld     <= 1'b0;
            r_unique    <= '0;
            r_invalid   <= '0;
            r_duplicate <= '0;
            r_empty     <= '0;
            r_error     <= 1'b0;
        end else begin
            if (i_accept) begin
                r_b_vld <= 1'b1;
            end else if (b_adv) begin
                r_b_vld <= 1'b0;
            end
            if (b_adv) begin
                r_o_vld     <= 1'b1;
                r_unique    <= n_unique;
                r_invalid   <= n_invalid;
                r_duplicate <= n_duplicate;
                r_empty     <= n_empty;
                r_error     <= n_error;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b <= i_item;
        end
        if (b_adv) begin
            r_kind     <= n_kind;
            r_value    <= n_value;
            r_position <= r_b.position;
            r_row_end  <= r_b.row_end;
        end
    end

    assign o_out.valid           = r_o_vld;
    assign o_out.kind            = r_kind;
    assign o_out.value           = r_value;
    assign o_out.position        = r_position;
    assign o_out.row_end         = r_row_end;
    assign o_out.unique_total    = r_unique;
    assign o_out.invalid_total   = r_invalid;
    assign o_out.duplicate_total = r_duplicate;
    assign o_out.empty_rows      = r_empty;
    assign o_out.error_seen      = r_error;

endmodule
